// ===== rtl/nfsa_pkg.sv =====
// Shared types, constants and helpers for the next-fit slot allocator.
`default_nettype none

package nfsa_pkg;

   // Usage map is kept as rows of eight slots.
   localparam int ROW_BITS     = 8;
   localparam int OFF_W        = 3;
   localparam int SLOT_FIELD_W = 8;

   localparam logic [ROW_BITS-1:0] ONE_HOT_BASE = 8'h01;

   localparam logic REQ_ALLOCATE = 1'b0;
   localparam logic REQ_RELEASE  = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REL_RD,
      ST_REL_WR
   } state_type;

   // Index of the lowest set bit of one map row.
   function automatic logic [OFF_W-1:0] first_set(input logic [ROW_BITS-1:0] vec);
      logic [OFF_W-1:0] idx;
      idx = '0;
      for (int i = ROW_BITS - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = OFF_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/nfsa_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none

module nfsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/next_fit_slot_allocator_top.sv =====
// Top level of the next-fit slot allocator: usage map RAM, scan sequencer and result register.
`default_nettype none

// Next-fit allocator over SLOT_COUNT slots. A transaction is taken when start is high and busy
// is low. An allocate walks the usage map one row of eight slots per cycle out of the map RAM,
// starting at the slot after the last grant and wrapping around; each row read passes through
// the RAM's registered read before the row is evaluated. A release reads and rewrites one row.
// Each result shows on rsp_slot and rsp_status for the single cycle that rsp_valid is high and
// cannot be held off by the receiver; busy drops in that same cycle so the next transaction may
// be taken. A full map returns status 1 with slot 0. Reset clears the per-row valid bits at
// once, so the block is ready right after reset with no clearing pass.
module next_fit_slot_allocator_top #(
   parameter int SLOT_COUNT = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_type,
   input  logic [nfsa_pkg::SLOT_FIELD_W-1:0] req_slot_index,
   output logic                              rsp_valid,
   output logic [nfsa_pkg::SLOT_FIELD_W-1:0] rsp_slot,
   output logic                              rsp_status
);

   import nfsa_pkg::*;

   localparam int ROWS   = (SLOT_COUNT + ROW_BITS - 1) / ROW_BITS;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int SW     = ROW_W + OFF_W;
   localparam int KW     = $clog2(ROWS + 2);
   localparam int WIDE_W = ((SW > SLOT_FIELD_W) ? SW : SLOT_FIELD_W) + 1;

   localparam logic [WIDE_W-1:0] COUNT_WIDE = WIDE_W'(SLOT_COUNT);
   localparam logic [KW-1:0]     LAST_VISIT = KW'(ROWS);
   localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);

   state_type state_ff, state_in;

   logic [SW-1:0]           last_granted_ff, last_granted_in;
   logic [SW-1:0]           cand_ff, cand_in;
   logic [ROW_W-1:0]        scan_row_ff, scan_row_in;
   logic [KW-1:0]           issue_k_ff, issue_k_in;
   logic                    eval_vld_ff, eval_vld_in;
   logic [ROW_W-1:0]        eval_row_ff, eval_row_in;
   logic [KW-1:0]           eval_k_ff, eval_k_in;
   logic [ROWS-1:0]         row_valid_ff, row_valid_in;
   logic [WIDE_W-1:0]       rel_idx_ff, rel_idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SLOT_FIELD_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic                    rsp_status_ff, rsp_status_in;

   logic                    ram_we;
   logic [ROW_W-1:0]        ram_waddr;
   logic [ROW_BITS-1:0]     ram_wdata;
   logic                    ram_re;
   logic [ROW_W-1:0]        ram_raddr;
   logic [ROW_BITS-1:0]     ram_rdata;

   logic                    accept;
   logic [SW-1:0]           cand_next;
   logic [WIDE_W-1:0]       last_plus_one;
   logic [SW-1:0]           rel_slot;
   logic [ROW_W-1:0]        rel_row;
   logic                    rel_in_range;
   logic [ROW_W-1:0]        data_row;
   logic [ROW_BITS-1:0]     row_data;
   logic [ROW_BITS-1:0]     elig;
   logic [ROW_BITS-1:0]     free_vec;
   logic [OFF_W-1:0]        pick;
   logic [SW-1:0]           found_slot;
   logic                    found;
   logic                    exhausted;
   logic [WIDE_W-1:0]       found_wide;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   nfsa_ram #(
      .WIDTH(ROW_BITS),
      .DEPTH(ROWS)
   ) u_map_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // Datapath: scan start point, row evaluation and release decode.
   always_comb begin
      logic [SW-1:0] bit_slot;
      last_plus_one = WIDE_W'(last_granted_ff) + WIDE_W'(1);
      cand_next     = (last_plus_one == COUNT_WIDE) ? '0 : last_plus_one[SW-1:0];

      rel_slot     = rel_idx_ff[SW-1:0];
      rel_row      = rel_slot[SW-1:OFF_W];
      rel_in_range = (rel_idx_ff < COUNT_WIDE);

      data_row = (state_ff == ST_REL_WR) ? rel_row : eval_row_ff;
      // A row never written reads as all free.
      row_data = row_valid_ff[data_row] ? ram_rdata : '0;

      bit_slot = '0;
      for (int b = 0; b < ROW_BITS; b++) begin
         bit_slot = {eval_row_ff, OFF_W'(b)};
         elig[b]  = (WIDE_W'(bit_slot) < COUNT_WIDE)
                    && (bit_slot != last_granted_ff)
                    && ((eval_k_ff != '0) || (OFF_W'(b) >= cand_ff[OFF_W-1:0]))
                    && ((eval_k_ff != LAST_VISIT) || (OFF_W'(b) < cand_ff[OFF_W-1:0]));
      end

      free_vec   = ~row_data & elig;
      pick       = first_set(free_vec);
      found_slot = {eval_row_ff, pick};
      found_wide = WIDE_W'(found_slot);
      found      = (state_ff == ST_SCAN) && eval_vld_ff && (|free_vec);
      exhausted  = (state_ff == ST_SCAN) && eval_vld_ff && !(|free_vec)
                   && (eval_k_ff == LAST_VISIT);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_type == REQ_RELEASE) ? ST_REL_RD : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (found || exhausted) begin
               state_in = ST_IDLE;
            end
         end
         ST_REL_RD: state_in = ST_REL_WR;
         ST_REL_WR: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs and register updates.
   always_comb begin
      ram_we          = 1'b0;
      ram_waddr       = eval_row_ff;
      ram_wdata       = row_data;
      ram_re          = 1'b0;
      ram_raddr       = scan_row_ff;
      last_granted_in = last_granted_ff;
      cand_in         = cand_ff;
      scan_row_in     = scan_row_ff;
      issue_k_in      = issue_k_ff;
      eval_vld_in     = 1'b0;
      eval_row_in     = eval_row_ff;
      eval_k_in       = eval_k_ff;
      row_valid_in    = row_valid_ff;
      rel_idx_in      = rel_idx_ff;
      rsp_valid_in    = 1'b0;
      rsp_slot_in     = rsp_slot_ff;
      rsp_status_in   = rsp_status_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cand_in     = cand_next;
               scan_row_in = cand_next[SW-1:OFF_W];
               issue_k_in  = '0;
               rel_idx_in  = WIDE_W'(req_slot_index);
            end
         end
         ST_SCAN: begin
            if (found) begin
               ram_we                  = 1'b1;
               ram_waddr               = eval_row_ff;
               ram_wdata               = row_data | (ONE_HOT_BASE << pick);
               row_valid_in[eval_row_ff] = 1'b1;
               last_granted_in         = found_slot;
               rsp_valid_in            = 1'b1;
               rsp_slot_in             = found_wide[SLOT_FIELD_W-1:0];
               rsp_status_in           = STATUS_OK;
            end else if (exhausted) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = '0;
               rsp_status_in = STATUS_FULL;
            end else if (issue_k_ff <= LAST_VISIT) begin
               // Issue the next row read; its data is evaluated in the next cycle.
               ram_re      = 1'b1;
               ram_raddr   = scan_row_ff;
               scan_row_in = (scan_row_ff == LAST_ROW) ? '0 : scan_row_ff + ROW_W'(1);
               issue_k_in  = issue_k_ff + KW'(1);
               eval_vld_in = 1'b1;
               eval_row_in = scan_row_ff;
               eval_k_in   = issue_k_ff;
            end
         end
         ST_REL_RD: begin
            ram_re    = 1'b1;
            ram_raddr = rel_row;
         end
         ST_REL_WR: begin
            if (rel_in_range) begin
               ram_we                = 1'b1;
               ram_waddr             = rel_row;
               ram_wdata             = row_data & ~(ONE_HOT_BASE << rel_slot[OFF_W-1:0]);
               row_valid_in[rel_row] = 1'b1;
            end
            rsp_valid_in  = 1'b1;
            rsp_slot_in   = rel_idx_ff[SLOT_FIELD_W-1:0];
            rsp_status_in = STATUS_OK;
         end
         default: begin
            eval_vld_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         last_granted_ff <= '0;
         eval_vld_ff     <= 1'b0;
         row_valid_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
         issue_k_ff      <= '0;
      end else begin
         state_ff        <= state_in;
         last_granted_ff <= last_granted_in;
         eval_vld_ff     <= eval_vld_in;
         row_valid_ff    <= row_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         issue_k_ff      <= issue_k_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff       <= cand_in;
      scan_row_ff   <= scan_row_in;
      eval_row_ff   <= eval_row_in;
      eval_k_ff     <= eval_k_in;
      rel_idx_ff    <= rel_idx_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_status = rsp_status_ff;

   // A taken transaction always keeps the block busy for the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after a transaction was taken");

   // Results are raised only from a busy state and the block is idle while the strobe is high, so strobes never abut.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe high on consecutive cycles");

   // A failed allocation leaves the pointer where it was.
   a_full_keeps_ptr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_FULL)) |-> $stable(last_granted_ff))
      else $error("pointer moved on a failed allocation");

   // No row evaluation is pending once the block is idle.
   a_idle_no_eval: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !eval_vld_ff)
      else $error("row evaluation pending while idle");

endmodule

`default_nettype wire

// ===== test/next_fit_slot_allocator_checker.sv =====
// Checker for the next-fit slot allocator: predicts each answer and compares it on the response port.
module next_fit_slot_allocator_checker #(
   parameter int SLOT_COUNT = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic                              req_type,
   input  logic [nfsa_pkg::SLOT_FIELD_W-1:0] req_slot_index,
   input  logic                              rsp_valid,
   input  logic [nfsa_pkg::SLOT_FIELD_W-1:0] rsp_slot,
   input  logic                              rsp_status,
   output int                                fail_count,
   output int                                outstanding,
   output int                                grant_count,
   output int                                full_count,
   output int                                release_count
);
   import nfsa_pkg::*;

   typedef struct packed {
      logic [SLOT_FIELD_W-1:0] slot;
      logic                    status;
   } answer_type;

   logic        slot_used [SLOT_COUNT];
   int unsigned last_grant;
   answer_type  answer_q [$];

   task automatic report(input string what, input int got, input int want);
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   // Apply one transaction to the shadow map and return the answer it earns.
   function automatic answer_type serve_next_fit(input logic kind, input logic [7:0] idx);
      answer_type  ans;
      int unsigned cand;
      ans.slot   = idx;
      ans.status = STATUS_OK;
      if (kind == REQ_RELEASE) begin
         if (idx < SLOT_COUNT) slot_used[idx] = 1'b0;
         return ans;
      end
      // The slot under the pointer itself is never looked at.
      cand = (last_grant + 1) % SLOT_COUNT;
      while (cand != last_grant) begin
         if (!slot_used[cand]) begin
            slot_used[cand] = 1'b1;
            last_grant      = cand;
            ans.slot        = SLOT_FIELD_W'(cand);
            return ans;
         end
         cand = (cand + 1) % SLOT_COUNT;
      end
      ans.slot   = '0;
      ans.status = STATUS_FULL;
      return ans;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         foreach (slot_used[i]) slot_used[i] = 1'b0;
         last_grant = 0;
         answer_q.delete();
      end else begin
         if (rsp_valid) begin
            if (answer_q.size() == 0) begin
               report("answer with no transaction outstanding", rsp_slot, 0);
            end else begin
               want = answer_q.pop_front();
               if (rsp_slot !== want.slot) report("slot", rsp_slot, want.slot);
               if (rsp_status !== want.status) report("status", rsp_status, want.status);
            end
         end
         if (start && !busy) begin
            want = serve_next_fit(req_type, req_slot_index);
            answer_q.push_back(want);
            if (req_type == REQ_RELEASE) release_count <= release_count + 1;
            else if (want.status == STATUS_FULL) full_count <= full_count + 1;
            else grant_count <= grant_count + 1;
         end
      end
      outstanding <= answer_q.size();
   end

endmodule

// ===== test/next_fit_slot_allocator_top_tb.sv =====
// Testbench top for the next-fit slot allocator: clock, reset, stimulus, watchdog and verdict.
module next_fit_slot_allocator_top_tb;
   import nfsa_pkg::*;

   localparam int SLOT_COUNT  = 256;
   // Slowest step is a long sender gap plus a full scan; this is many times that.
   localparam int STALL_LIMIT = 2000;
   localparam int TAIL_CYCLES = 40;

   logic                    clock          = 1'b0;
   logic                    reset          = 1'b1;
   logic                    start          = 1'b0;
   logic                    req_type       = REQ_ALLOCATE;
   logic [SLOT_FIELD_W-1:0] req_slot_index = '0;
   wire                     busy;
   wire                     rsp_valid;
   wire  [SLOT_FIELD_W-1:0] rsp_slot;
   wire                     rsp_status;

   int fail_count;
   int outstanding;
   int grant_count;
   int full_count;
   int release_count;
   int idle_cycles = 0;
   bit quiet_run   = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   next_fit_slot_allocator_top #(.SLOT_COUNT(SLOT_COUNT)) DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_slot_index (req_slot_index),
      .rsp_valid      (rsp_valid),
      .rsp_slot       (rsp_slot),
      .rsp_status     (rsp_status)
   );

   next_fit_slot_allocator_checker #(.SLOT_COUNT(SLOT_COUNT)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_slot_index (req_slot_index),
      .rsp_valid      (rsp_valid),
      .rsp_slot       (rsp_slot),
      .rsp_status     (rsp_status),
      .fail_count     (fail_count),
      .outstanding    (outstanding),
      .grant_count    (grant_count),
      .full_count     (full_count),
      .release_count  (release_count)
   );

   // Abort when neither a transaction nor an answer moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
         $display("watchdog expired after %0d idle cycles", STALL_LIMIT);
         $display("next_fit_slot_allocator_top verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int pick_gap();
      int r;
      if (quiet_run) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Present one transaction and hold it until the block takes it.
   task automatic issue(input logic kind, input logic [SLOT_FIELD_W-1:0] idx);
      int gap;
      gap = pick_gap();
      repeat (gap) @(negedge clock) start <= 1'b0;
      @(negedge clock);
      start          <= 1'b1;
      req_type       <= kind;
      req_slot_index <= idx;
      do @(posedge clock); while (busy);
   endtask

   task automatic allocate_any();
      issue(REQ_ALLOCATE, SLOT_FIELD_W'($urandom_range(0, 255)));
   endtask

   // Hold off the sender until every answer is back.
   task automatic drain();
      @(negedge clock) start <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   initial begin
      logic [SLOT_FIELD_W-1:0] victim;
      int                      random_items;
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed corners: first grants, releases of free and in-use slots, field extremes.
      issue(REQ_ALLOCATE, 8'hFF);
      issue(REQ_ALLOCATE, 8'h00);
      issue(REQ_ALLOCATE, 8'hA5);
      issue(REQ_RELEASE, 8'd2);
      issue(REQ_RELEASE, 8'd2);
      issue(REQ_RELEASE, 8'd0);
      issue(REQ_RELEASE, 8'd255);
      issue(REQ_ALLOCATE, 8'h5A);
      issue(REQ_RELEASE, 8'd1);
      issue(REQ_ALLOCATE, 8'h80);
      issue(REQ_RELEASE, 8'hAA);
      issue(REQ_RELEASE, 8'h55);
      issue(REQ_RELEASE, 8'h80);
      issue(REQ_RELEASE, 8'h7F);
      issue(REQ_ALLOCATE, 8'h7F);
      issue(REQ_ALLOCATE, 8'h01);
      issue(REQ_RELEASE, 8'd3);
      issue(REQ_ALLOCATE, 8'hFE);
      drain();

      // Run the map to exhaustion: the pointer wraps and slot 0 is finally reached.
      quiet_run = 1'b0;
      repeat (SLOT_COUNT + 2) allocate_any();
      drain();
      // Free one slot in a full map, take it back, then free the pointer slot: no grant possible.
      victim = SLOT_FIELD_W'($urandom_range(0, SLOT_COUNT - 1));
      issue(REQ_RELEASE, victim);
      issue(REQ_ALLOCATE, ~victim);
      issue(REQ_RELEASE, victim);
      issue(REQ_ALLOCATE, victim);
      issue(REQ_ALLOCATE, 8'h00);

      // Churn on a nearly full map.
      repeat (60) begin
         if ($urandom_range(0, 1)) issue(REQ_RELEASE, SLOT_FIELD_W'($urandom_range(0, 255)));
         else allocate_any();
      end
      drain();

      // Random mix in chunks, some chunks back to back with no gaps.
      random_items = 0;
      while (random_items < 500) begin
         quiet_run = ($urandom_range(0, 3) == 0);
         repeat (50) begin
            if ($urandom_range(0, 99) < 62) allocate_any();
            else issue(REQ_RELEASE, SLOT_FIELD_W'($urandom_range(0, 255)));
         end
         random_items += 50;
         if ($urandom_range(0, 4) == 0) drain();
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Covered %0d grants, %0d refusals on a full map and %0d releases,",
               grant_count, full_count, release_count);
      $display("with a wrap to exhaustion and a freed pointer slot that stayed unreachable.");
      if (fail_count == 0 && outstanding == 0) begin
         $display("next_fit_slot_allocator_top verification clean");
      end else begin
         $display("next_fit_slot_allocator_top verification failed");
      end
      $finish;
   end

endmodule
